// ----- rtl/text_console_glyph_renderer_assert.svh -----
// Assertion macros shared by the glyph renderer's checker.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glyph renderer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glyph renderer check failed");

`endif

// ----- rtl/tcgr_pkg.sv -----
// Package for the text console glyph renderer: constants, codes and types.
// Used by the font store, the row sequencer and the top level; depends on nothing.
package tcgr_pkg;

	// Defaults of the top-level parameters.
	localparam int FONT_BYTES_DEF      = 4096;
	localparam int MAX_GLYPH_WIDTH_DEF = 16;

	// Character codes.
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_SUBST   = 8'd63;
	localparam logic [7:0] CURSOR_MAX   = 8'd255;

	// Glyph geometry limits.
	localparam logic [4:0] MAX_ROWS = 5'd16;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GLYPH_WIDTH   = 2'd0,
		CFG_GLYPH_HEIGHT  = 2'd1,
		CFG_BYTES_PER_ROW = 2'd2,
		CFG_COLUMN_LIMIT  = 2'd3
	} cfg_reg_t;

	// Register reset values.
	localparam logic [4:0] GLYPH_WIDTH_RST   = 5'd11;
	localparam logic [4:0] GLYPH_HEIGHT_RST  = 5'd16;
	localparam logic [1:0] BYTES_PER_ROW_RST = 2'd2;
	localparam logic [7:0] COLUMN_LIMIT_RST  = 8'd29;

	// Row sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_RD0,
		ST_RD1,
		ST_EMIT
	} seq_state_t;

	// Command from the top level to the row sequencer.
	typedef struct packed {
		logic       start;
		logic [6:0] glyph_idx;
		logic [4:0] width;
		logic [4:0] height;
		logic       two_bytes;
		logic [7:0] col;
		logic [7:0] row;
	} seq_cmd_t;

	// Status from the row sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage

// ----- rtl/tcgr_font_mem.sv -----
// Font store: single write port, single read port with registered read data.
// Depends on tcgr_pkg for the default depth.
module tcgr_font_mem #(
	parameter int FONT_BYTES = tcgr_pkg::FONT_BYTES_DEF,
	parameter int AW         = $clog2(FONT_BYTES)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] font_q [FONT_BYTES];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			font_q[wr_addr] <= wr_data;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		rd_data_q <= font_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/tcgr_seq.sv -----
// Row sequencer: walks the rows of one glyph with a shared address adder,
// reads the font store and loads the result register. Depends on tcgr_pkg.
module tcgr_seq #(
	parameter int AW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcgr_pkg::seq_cmd_t  cmd,
	output tcgr_pkg::seq_stat_t stat,
	output logic [AW-1:0]       mem_raddr,
	input  logic [7:0]          mem_rdata,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [11:0]         pixel_x,
	output logic [11:0]         pixel_y,
	output logic [15:0]         row_bits,
	output logic                last_row
);

	tcgr_pkg::seq_state_t state_q, state_d;

	logic [6:0]    idx_q;
	logic [AW-1:0] addr_q;
	logic [11:0]   px_q;
	logic [11:0]   rowh_q;
	logic [3:0]    r_q;
	logic [7:0]    byte0_q;

	logic          out_valid_q;
	logic [11:0]   pixel_x_q;
	logic [11:0]   pixel_y_q;
	logic [15:0]   row_bits_q;
	logic          last_row_q;

	logic [5:0]    stride;
	logic [12:0]   base_prod;
	logic [12:0]   px_prod;
	logic [12:0]   rowh_prod;
	logic          inc;
	logic [AW-1:0] addr_sum;
	logic          out_free;
	logic          is_last;
	logic          load;
	logic [15:0]   mask;
	logic [11:0]   py_cur;

	// Glyph start address and pixel origins; registered before use.
	assign stride    = cmd.two_bytes ? {cmd.height, 1'b0} : {1'b0, cmd.height};
	assign base_prod = 13'(idx_q * stride);
	assign px_prod   = 13'(cmd.col * cmd.width);
	assign rowh_prod = 13'(cmd.row * cmd.height);

	// Shared address adder: next byte of the row, or on to the next row.
	assign inc      = (state_q == tcgr_pkg::ST_RD0) ? 1'b1 : cmd.two_bytes;
	assign addr_sum = addr_q + AW'(inc);

	assign mem_raddr = addr_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign is_last   = (5'({1'b0, r_q} + 5'd1) == cmd.height);
	assign mask      = ~(16'hFFFF >> cmd.width);
	assign py_cur    = rowh_q + {8'd0, r_q};

	// Next state and load control.
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		case (state_q)
			tcgr_pkg::ST_IDLE: begin
				if (cmd.start) begin
					state_d = tcgr_pkg::ST_MULT;
				end
			end
			tcgr_pkg::ST_MULT: state_d = tcgr_pkg::ST_RD0;
			tcgr_pkg::ST_RD0:  state_d = tcgr_pkg::ST_RD1;
			tcgr_pkg::ST_RD1:  state_d = tcgr_pkg::ST_EMIT;
			tcgr_pkg::ST_EMIT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = is_last ? tcgr_pkg::ST_IDLE : tcgr_pkg::ST_RD0;
				end
			end
			default: state_d = tcgr_pkg::ST_IDLE;
		endcase
	end

	assign stat.busy = (state_q != tcgr_pkg::ST_IDLE);
	assign stat.done = load && is_last;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the glyph walk.
	always_ff @(posedge clk) begin
		case (state_q)
			tcgr_pkg::ST_IDLE: begin
				idx_q <= cmd.glyph_idx;
			end
			tcgr_pkg::ST_MULT: begin
				addr_q <= AW'(base_prod);
				px_q   <= px_prod[11:0];
				rowh_q <= rowh_prod[11:0];
				r_q    <= 4'd0;
			end
			tcgr_pkg::ST_RD0: begin
				addr_q <= addr_sum;
			end
			tcgr_pkg::ST_RD1: begin
				byte0_q <= mem_rdata;
			end
			tcgr_pkg::ST_EMIT: begin
				if (load) begin
					addr_q <= addr_sum;
					r_q    <= r_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			pixel_x_q  <= px_q;
			pixel_y_q  <= py_cur;
			row_bits_q <= {byte0_q, mem_rdata} & mask;
			last_row_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign row_bits  = row_bits_q;
	assign last_row  = last_row_q;

endmodule

// ----- rtl/text_console_glyph_renderer.sv -----
// Text console glyph renderer, built on tcgr_pkg, tcgr_font_mem and tcgr_seq.
// Font loads, ignored codes, newlines and characters past the column limit never stall the input.
// A drawn character of H glyph rows is taken, then the address products are registered, then for
// each row come two font store reads and a load of the result register. A stalled result holds
// the sequencer at that load until the result side takes the waiting row.
// Reset is asynchronous, active low: cursor cleared, registers to defaults, font kept.
module text_console_glyph_renderer #(
	parameter int FONT_BYTES      = tcgr_pkg::FONT_BYTES_DEF,
	parameter int MAX_GLYPH_WIDTH = tcgr_pkg::MAX_GLYPH_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  char_code,
	input  logic [11:0] font_address,
	input  logic [7:0]  font_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [15:0] row_bits,
	output logic        last_row
);

	localparam int AW = $clog2(FONT_BYTES);

	logic [4:0] glyph_width_q;
	logic [4:0] glyph_height_q;
	logic [1:0] bytes_per_row_q;
	logic [7:0] column_limit_q;
	logic [7:0] cursor_row_q;
	logic [7:0] cursor_col_q;

	tcgr_pkg::seq_cmd_t  cmd;
	tcgr_pkg::seq_stat_t stat;

	logic          accept;
	logic          print_txn;
	logic          is_newline;
	logic          in_view;
	logic [7:0]    code_eff;
	logic [4:0]    width_eff;
	logic [4:0]    height_eff;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// Input transaction decode.
	assign in_stall   = stat.busy;
	assign accept     = in_valid && !in_stall;
	assign print_txn  = accept && !mode && !char_code[7];
	assign is_newline = (char_code == tcgr_pkg::CODE_NEWLINE);
	assign in_view    = (cursor_col_q < column_limit_q);
	assign code_eff   = (char_code < tcgr_pkg::CODE_FIRST) ? tcgr_pkg::CODE_SUBST : char_code;

	// Register ranges are saturated before use.
	always_comb begin
		if (glyph_width_q == 5'd0) begin
			width_eff = 5'd1;
		end else if (glyph_width_q > 5'(MAX_GLYPH_WIDTH)) begin
			width_eff = 5'(MAX_GLYPH_WIDTH);
		end else begin
			width_eff = glyph_width_q;
		end
		if (glyph_height_q == 5'd0) begin
			height_eff = 5'd1;
		end else if (glyph_height_q > tcgr_pkg::MAX_ROWS) begin
			height_eff = tcgr_pkg::MAX_ROWS;
		end else begin
			height_eff = glyph_height_q;
		end
	end

	// Command to the row sequencer.
	assign cmd.start     = print_txn && !is_newline && in_view;
	assign cmd.glyph_idx = 7'(code_eff - tcgr_pkg::CODE_FIRST);
	assign cmd.width     = width_eff;
	assign cmd.height    = height_eff;
	assign cmd.two_bytes = bytes_per_row_q[1];
	assign cmd.col       = cursor_col_q;
	assign cmd.row       = cursor_row_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q   <= tcgr_pkg::GLYPH_WIDTH_RST;
			glyph_height_q  <= tcgr_pkg::GLYPH_HEIGHT_RST;
			bytes_per_row_q <= tcgr_pkg::BYTES_PER_ROW_RST;
			column_limit_q  <= tcgr_pkg::COLUMN_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tcgr_pkg::CFG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[4:0];
				tcgr_pkg::CFG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[4:0];
				tcgr_pkg::CFG_BYTES_PER_ROW: bytes_per_row_q <= cfg_data[1:0];
				tcgr_pkg::CFG_COLUMN_LIMIT:  column_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Text cursor. The column moves on once a character has been drawn or skipped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= 8'd0;
			cursor_col_q <= 8'd0;
		end else if (print_txn && is_newline) begin
			if (cursor_row_q != tcgr_pkg::CURSOR_MAX) begin
				cursor_row_q <= cursor_row_q + 8'd1;
			end
			cursor_col_q <= 8'd0;
		end else if ((print_txn && !in_view) || stat.done) begin
			if (cursor_col_q != tcgr_pkg::CURSOR_MAX) begin
				cursor_col_q <= cursor_col_q + 8'd1;
			end
		end
	end

	tcgr_font_mem #(
		.FONT_BYTES(FONT_BYTES),
		.AW        (AW)
	) u_font_mem (
		.clk    (clk),
		.wr_en  (accept && mode),
		.wr_addr(AW'(font_address)),
		.wr_data(font_byte),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	tcgr_seq #(
		.AW(AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.row_bits (row_bits),
		.last_row (last_row)
	);

endmodule

// ----- rtl/tcgr_checker.sv -----
// Port-level checks for the glyph renderer, attached by a bind at the end.
// Depends on text_console_glyph_renderer_assert.svh for the assertion macros.
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        mode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] pixel_x,
	input logic [11:0] pixel_y,
	input logic [15:0] row_bits,
	input logic        last_row
);

	logic [40:0] out_payload;

	// The whole result payload, for the hold check.
	assign out_payload = {pixel_x, pixel_y, row_bits, last_row};

	// A stalled result transaction is held with its payload.
	`TCGR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_payload))

	// A font load completes in the cycle it is taken.
	`TCGR_ASSERT_NEXT(a_load_quick, clk, arst_n, in_valid && !in_stall && mode, !in_stall)

	// While the input is open, any waiting result must be a glyph's final row.
	`TCGR_ASSERT_NOW(a_idle_last, clk, arst_n, !in_stall && out_valid, last_row)

	// A result that is not the final row is followed by more work on the glyph.
	`TCGR_ASSERT_NOW(a_mid_busy, clk, arst_n, out_valid && !last_row, in_stall)

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

// ----- sim/text_console_glyph_renderer_tb.sv -----
// Self-checking testbench for text_console_glyph_renderer: a scoreboard class predicts every
// glyph row from the font loads and characters that the block accepts, and checks each row.
// Depends on tcgr_pkg and the text_console_glyph_renderer RTL only.
`timescale 1ns / 100ps

module text_console_glyph_renderer_tb;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int LONG_HOLD     = 150;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 60;
	localparam int FONT_FILL     = 64;
	localparam int GLYPH_SLOTS   = 96;

	// One glyph row as the block reports it.
	typedef struct packed {
		logic [11:0] px;
		logic [11:0] py;
		logic [15:0] bits;
		logic        is_last;
	} glyph_row_t;

	// Glyph row predictor: its own copy of the font store, the cursor and the registers.
	class glyph_row_scoreboard;
		logic [7:0]  font_mem [tcgr_pkg::FONT_BYTES_DEF];
		logic [7:0]  cur_row;
		logic [7:0]  cur_col;
		logic [4:0]  gw;
		logic [4:0]  gh;
		logic [1:0]  bpr;
		logic [7:0]  col_limit;
		glyph_row_t  rows_due [$];
		int unsigned errors;

		function new();
			cur_row   = '0;
			cur_col   = '0;
			gw        = tcgr_pkg::GLYPH_WIDTH_RST;
			gh        = tcgr_pkg::GLYPH_HEIGHT_RST;
			bpr       = tcgr_pkg::BYTES_PER_ROW_RST;
			col_limit = tcgr_pkg::COLUMN_LIMIT_RST;
			errors    = 0;
		endfunction

		function int clamp_range(int v, int lo, int hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(tcgr_pkg::cfg_reg_t idx, logic [7:0] v);
			case (idx)
				tcgr_pkg::CFG_GLYPH_WIDTH:   gw = v[4:0];
				tcgr_pkg::CFG_GLYPH_HEIGHT:  gh = v[4:0];
				tcgr_pkg::CFG_BYTES_PER_ROW: bpr = v[1:0];
				tcgr_pkg::CFG_COLUMN_LIMIT:  col_limit = v;
				default: ;
			endcase
		endfunction

		// Highest font address that a glyph reads under the present registers.
		function int last_addr(int idx);
			int w, h, b;
			w = clamp_range(int'(gw), 1, tcgr_pkg::MAX_GLYPH_WIDTH_DEF);
			h = clamp_range(int'(gh), 1, int'(tcgr_pkg::MAX_ROWS));
			b = clamp_range(int'(bpr), 1, 2);
			return (idx + 1) * b * h - b + ((w > 8) ? 1 : 0);
		endfunction

		// A glyph may be printed only if every byte it reads lies in the loaded area.
		function bit glyph_fits(int idx);
			return last_addr(idx) < FONT_FILL;
		endfunction

		function int glyph_count();
			int n;
			n = 0;
			while (n < GLYPH_SLOTS && glyph_fits(n))
				n++;
			return n;
		endfunction

		// Works out the glyph rows that one accepted input transaction causes.
		function void note_input(logic m, logic [7:0] code, logic [11:0] addr, logic [7:0] data);
			int w, h, b, base, start;
			logic [7:0] c, fb;
			glyph_row_t gr;
			if (m) begin
				font_mem[addr] = data;
				return;
			end
			if (code[7])
				return;
			if (code == tcgr_pkg::CODE_NEWLINE) begin
				if (cur_row != tcgr_pkg::CURSOR_MAX)
					cur_row++;
				cur_col = '0;
				return;
			end
			// Control codes are drawn as the substitute character.
			c = (code < tcgr_pkg::CODE_FIRST) ? tcgr_pkg::CODE_SUBST : code;
			if (cur_col < col_limit) begin
				w = clamp_range(int'(gw), 1, tcgr_pkg::MAX_GLYPH_WIDTH_DEF);
				h = clamp_range(int'(gh), 1, int'(tcgr_pkg::MAX_ROWS));
				b = clamp_range(int'(bpr), 1, 2);
				base = (int'(c) - int'(tcgr_pkg::CODE_FIRST)) * b * h;
				for (int r = 0; r < h; r++) begin
					start = base + r * b;
					gr.bits = '0;
					// Pixels run MSB first, spilling into the following bytes.
					for (int j = 0; j < w; j++) begin
						fb = font_mem[(start + j / 8) % tcgr_pkg::FONT_BYTES_DEF];
						if (fb[7 - j % 8])
							gr.bits[15 - j] = 1'b1;
					end
					gr.px      = 12'(int'(cur_col) * w);
					gr.py      = 12'(int'(cur_row) * h + r);
					gr.is_last = (r == h - 1);
					rows_due.push_back(gr);
				end
			end
			if (cur_col != tcgr_pkg::CURSOR_MAX)
				cur_col++;
		endfunction

		// Compares one accepted output transaction with the oldest expected row.
		function void check_result(glyph_row_t got);
			glyph_row_t want;
			if (rows_due.size() == 0) begin
				$error("unexpected glyph row: pixel_x %0d pixel_y %0d row_bits %h",
					got.px, got.py, got.bits);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			if (got.px !== want.px) begin
				$error("pixel_x: expected %0d, actual %0d", want.px, got.px);
				errors++;
			end
			if (got.py !== want.py) begin
				$error("pixel_y: expected %0d, actual %0d", want.py, got.py);
				errors++;
			end
			if (got.bits !== want.bits) begin
				$error("row_bits: expected %h, actual %h", want.bits, got.bits);
				errors++;
			end
			if (got.is_last !== want.is_last) begin
				$error("last_row: expected %0b, actual %0b", want.is_last, got.is_last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [7:0]  char_code = '0;
	logic [11:0] font_address = '0;
	logic [7:0]  font_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [15:0] row_bits;
	logic        last_row;

	glyph_row_scoreboard sb;
	bit          calm = 1'b0;
	bit          long_hold_req = 1'b0;
	int unsigned cycle_count = 0;

	text_console_glyph_renderer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.font_address (font_address),
		.font_byte    (font_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.row_bits     (row_bits),
		.last_row     (last_row)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** text_console_glyph_renderer: FAILED **");
			$finish;
		end
	end

	// Result side: checks each accepted row, then chooses the stall for the next cycle.
	initial begin : row_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(glyph_row_t'{pixel_x, pixel_y, row_bits, last_row});
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one input transaction, with an occasional idle burst first, and waits for it
	// to be taken. Valid stays high afterwards so that transactions can run back to back.
	task automatic send_item(logic m, logic [7:0] code, logic [11:0] addr, logic [7:0] data);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		char_code    <= code;
		font_address <= addr;
		font_byte    <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(m, code, addr, data);
	endtask

	task automatic send_char(logic [7:0] code);
		send_item(1'b0, code, 12'($urandom), 8'($urandom));
	endtask

	task automatic load_byte(logic [11:0] addr, logic [7:0] data);
		send_item(1'b1, 8'($urandom), addr, data);
	endtask

	// A printable character whose glyph lies wholly in the loaded part of the font.
	task automatic send_fitting_char();
		send_char(8'(int'(tcgr_pkg::CODE_FIRST) + $urandom_range(0, sb.glyph_count() - 1)));
	endtask

	// Stops offering input until every expected row has come, then lets the block go quiet.
	task automatic settle_block(int extra);
		in_valid <= 1'b0;
		while (sb.rows_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_one(tcgr_pkg::cfg_reg_t idx, logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic apply_setting(logic [7:0] w, logic [7:0] h, logic [7:0] b, logic [7:0] cl);
		write_one(tcgr_pkg::CFG_GLYPH_WIDTH, w);
		write_one(tcgr_pkg::CFG_GLYPH_HEIGHT, h);
		write_one(tcgr_pkg::CFG_BYTES_PER_ROW, b);
		write_one(tcgr_pkg::CFG_COLUMN_LIMIT, cl);
		cfg_wr_en <= 1'b0;
	endtask

	// Random mix of characters, control codes, newlines, high codes and font loads. Only
	// glyphs inside the loaded part of the font are printed; control codes only when the
	// substitute glyph lies there too.
	task automatic run_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_char(8'($urandom_range(128, 255)));
			else if (pick < 18)
				load_byte(12'($urandom_range(0, FONT_FILL - 1)), 8'($urandom));
			else if (pick < 80 || !sb.glyph_fits(int'(tcgr_pkg::CODE_SUBST - tcgr_pkg::CODE_FIRST)))
				send_fitting_char();
			else if (pick < 90)
				send_char(8'($urandom_range(0, 31)));
			else
				send_char(tcgr_pkg::CODE_NEWLINE);
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Load the low part of the font; every printed glyph is kept inside it.
		for (int a = 0; a < FONT_FILL; a++)
			load_byte(12'(a), 8'($urandom));

		// Directed part under the reset settings.
		send_char(tcgr_pkg::CODE_FIRST);
		send_char(8'd33);
		send_char(8'd200);
		send_char(8'd128);
		send_char(tcgr_pkg::CODE_NEWLINE);
		load_byte(12'd0, 8'hFF);
		load_byte(12'd1, 8'h00);
		load_byte(12'd62, 8'hA5);
		load_byte(12'd63, 8'h5A);
		send_char(tcgr_pkg::CODE_FIRST);
		send_char(8'd33);
		settle_block(SETTLE_CYCLES);

		// Phases over several register settings, extremes and out-of-range values among them.
		apply_setting(8'd1, 8'd1, 8'd1, 8'd1);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd16, 8'd16, 8'd2, 8'd255);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd9, 8'd5, 8'd1, 8'd10);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd31, 8'd31, 8'd3, 8'd200);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd8, 8'd2, 8'd1, 8'd40);
		run_random(11);
		settle_block(SETTLE_CYCLES);
		apply_setting(8'd16, 8'd3, 8'd1, 8'd255);
		run_random(11);
		settle_block(SETTLE_CYCLES);

		// Back-pressure: the result side holds off while characters keep coming.
		apply_setting(8'd11, 8'd16, 8'd2, 8'd255);
		send_char(tcgr_pkg::CODE_NEWLINE);
		long_hold_req = 1'b1;
		for (int i = 0; i < 10; i++)
			send_fitting_char();
		settle_block(SETTLE_CYCLES);

		// Final stretch with no idling on either side.
		calm = 1'b1;
		apply_setting(8'd12, 8'd7, 8'd2, 8'd29);
		run_random(12);
		settle_block(TAIL_CYCLES);

		if (sb.rows_due.size() != 0) begin
			$error("%0d expected glyph rows never came", sb.rows_due.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("** text_console_glyph_renderer: PASSED **");
		else
			$display("** text_console_glyph_renderer: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_font_mem.sv
rtl/tcgr_seq.sv
rtl/text_console_glyph_renderer.sv
rtl/tcgr_checker.sv
sim/text_console_glyph_renderer_tb.sv
